// File: design/gaussian_aperture_field_mask_defines.svh
// ----------------------------------------------------------------------------
// Gaussian aperture field mask: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_APERTURE_FIELD_MASK_DEFINES_SVH
`define GAUSSIAN_APERTURE_FIELD_MASK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GAFM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GAFM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/gafm_pkg.sv
// ----------------------------------------------------------------------------
// Gaussian aperture field mask: package
// Payload types, register map, fixed-point constants and the exponent table.
// ----------------------------------------------------------------------------
package gafm_pkg;

   localparam int SAMPLE_BITS      = 32;
   localparam int MUL_W            = 32;
   localparam int PROD_W           = 2 * MUL_W;
   localparam int CFG_W            = 32;
   localparam int GRID_W           = 13;
   localparam int FRAC_BITS        = 24;
   localparam int FRAC_IDX_W       = $clog2(FRAC_BITS + 1);
   localparam int DEFAULT_MAX_GRID = 4096;

   // log2(e) in Q2.30 and the exponent cutoff of 24.0 in Q.24.
   localparam logic [MUL_W-1:0]  LOG2E_Q30  = 32'd1549082005;
   localparam logic [PROD_W-1:0] CUTOFF_Q24 = 64'd24 << FRAC_BITS;

   // Register reset values.
   localparam logic [GRID_W-1:0] RST_GRID_POINTS = 13'd256;
   localparam logic [CFG_W-1:0]  RST_PIXEL_PITCH = 32'd65536;
   localparam logic [CFG_W-1:0]  RST_X_OFFSET    = 32'd0;
   localparam logic [CFG_W-1:0]  RST_Y_OFFSET    = 32'd0;
   localparam logic [CFG_W-1:0]  RST_INV_TWO_R2  = 32'd16777216;
   localparam logic [CFG_W-1:0]  RST_AMP_ROOT    = 32'd65536;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_POINTS       = 3'd0,
      REG_PIXEL_PITCH       = 3'd1,
      REG_X_OFFSET          = 3'd2,
      REG_Y_OFFSET          = 3'd3,
      REG_INV_TWO_RADIUS_SQ = 3'd4,
      REG_AMPLITUDE_ROOT    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_re;
      logic signed [SAMPLE_BITS-1:0] sample_im;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] masked_re;
      logic signed [SAMPLE_BITS-1:0] masked_im;
      logic                          frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [GRID_W-1:0]       grid_points;
      logic [CFG_W-1:0]        pixel_pitch;
      logic signed [CFG_W-1:0] x_offset;
      logic signed [CFG_W-1:0] y_offset;
      logic [CFG_W-1:0]        inv_two_radius_sq;
      logic [CFG_W-1:0]        amplitude_root;
   } cfg_type;

   typedef logic [FRAC_BITS:0][MUL_W-1:0] frac_tab_type;

   // Bitwise integer square root, floor(sqrt(value)).
   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bit_w;
      rem   = value;
      root  = '0;
      bit_w = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= root + bit_w) begin
            rem  = rem - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   // Entry k holds 2^(-2^-k) in Q1.31, each one the square root of the last.
   function automatic frac_tab_type build_frac_tab();
      frac_tab_type tab;
      tab[0] = 32'd1 << 30;
      for (int k = 1; k <= FRAC_BITS; k++) begin
         tab[k] = MUL_W'(isqrt64(64'(tab[k-1]) << 31));
      end
      return tab;
   endfunction

   localparam frac_tab_type FRAC_TAB = build_frac_tab();

endpackage

// File: design/gafm_mult.sv
// ----------------------------------------------------------------------------
// Gaussian aperture field mask: shared multiplier
// Unsigned 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module gafm_mult (
   input  logic                          clock,
   input  logic                          mul_en,
   input  logic [gafm_pkg::MUL_W-1:0]    op_a,
   input  logic [gafm_pkg::MUL_W-1:0]    op_b,
   output logic [gafm_pkg::PROD_W-1:0]   product
);
   import gafm_pkg::*;

   logic [PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= PROD_W'(op_a) * PROD_W'(op_b);
      end
   end

   assign product = product_ff;

endmodule

// File: design/gafm_grid_counter.sv
// ----------------------------------------------------------------------------
// Gaussian aperture field mask: grid position counter
// Row and column counters over the clamped N by N grid, with the last flag.
// ----------------------------------------------------------------------------
module gafm_grid_counter #(
   parameter int MAX_GRID = gafm_pkg::DEFAULT_MAX_GRID
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [gafm_pkg::GRID_W-1:0]    grid_points,
   output logic [$clog2(MAX_GRID)-1:0]    row_index,
   output logic [$clog2(MAX_GRID)-1:0]    column_index,
   output logic [$clog2(MAX_GRID)-1:0]    grid_half,
   output logic                           frame_last
);
   import gafm_pkg::*;

   localparam int CNT_W = $clog2(MAX_GRID);
   localparam int GW    = (CNT_W + 1 > GRID_W) ? CNT_W + 1 : GRID_W;

   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [GW-1:0]    grid_ext;
   logic [GW-1:0]    n_eff;
   logic             last_col;
   logic             last_row;

   always_comb begin
      grid_ext = GW'(grid_points);
      if (grid_ext < GW'(2)) begin
         n_eff = GW'(2);
      end else if (grid_ext > GW'(MAX_GRID)) begin
         n_eff = GW'(MAX_GRID);
      end else begin
         n_eff = grid_ext;
      end

      // A counter left beyond N-1 by a smaller N also counts as last.
      last_col = (GW'(col_ff) + GW'(1)) >= n_eff;
      last_row = (GW'(row_ff) + GW'(1)) >= n_eff;

      row_in = row_ff;
      col_in = col_ff;
      if (advance) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign row_index    = row_ff;
   assign column_index = col_ff;
   assign grid_half    = n_eff[CNT_W:1];
   assign frame_last   = last_col && last_row;

endmodule

// File: design/gafm_core.sv
// ----------------------------------------------------------------------------
// Gaussian aperture field mask: sequencer and datapath
// Steps one sample through coordinates, exponent, gain and both products on
// the shared multiplier, then holds the result in the output register.
// ----------------------------------------------------------------------------
module gafm_core #(
   parameter int MAX_GRID = gafm_pkg::DEFAULT_MAX_GRID
) (
   input  logic                           clock,
   input  logic                           reset,
   input  gafm_pkg::cfg_type              cfg,
   input  logic                           start,
   input  gafm_pkg::req_payload_type      req_data,
   input  logic [$clog2(MAX_GRID)-1:0]    row_index,
   input  logic [$clog2(MAX_GRID)-1:0]    column_index,
   input  logic [$clog2(MAX_GRID)-1:0]    grid_half,
   input  logic                           frame_last,
   output logic                           busy,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output gafm_pkg::rsp_payload_type      rsp_data
);
   import gafm_pkg::*;

   localparam int CNT_W = $clog2(MAX_GRID);
   localparam int PW    = CNT_W + MUL_W;
   localparam int XW    = CNT_W + MUL_W + 2;
   localparam int Q_W   = PROD_W - 16;
   localparam int SB    = SAMPLE_BITS;
   localparam logic [XW-1:0]  COORD_SAT = XW'(64'd1 << 31);
   localparam logic [Q_W-1:0] SAT_POS   = Q_W'((64'd1 << (SB - 1)) - 64'd1);
   localparam logic [Q_W-1:0] SAT_NEG   = Q_W'(64'd1 << (SB - 1));
   localparam logic [MUL_W-1:0] G_ONE   = MUL_W'(64'd1 << 31);

   typedef enum logic [4:0] {
      ST_IDLE, ST_CROW, ST_CCOL, ST_SQX, ST_SQY, ST_SUMS, ST_ELO, ST_EHI,
      ST_ESUM, ST_TMUL, ST_TGET, ST_FRAC, ST_GAIN, ST_MRE, ST_MIM, ST_SIM,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic             row_neg_ff, row_neg_in;
   logic [CNT_W-1:0] row_mag_ff, row_mag_in;
   logic             col_neg_ff, col_neg_in;
   logic [CNT_W-1:0] col_mag_ff, col_mag_in;
   logic             re_neg_ff, re_neg_in;
   logic [SB-1:0]    re_mag_ff, re_mag_in;
   logic             im_neg_ff, im_neg_in;
   logic [SB-1:0]    im_mag_ff, im_mag_in;
   logic             frame_ff, frame_in;
   logic [MUL_W-1:0] ax_ff, ax_in;
   logic [MUL_W-1:0] ay_ff, ay_in;
   logic [PROD_W-1:0] s_ff, s_in;
   logic [MUL_W-1:0] acc_ff, acc_in;
   logic [MUL_W-1:0] e_ff, e_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [5:0]       tint_ff, tint_in;
   logic [MUL_W-1:0] g_ff, g_in;
   logic             pend_ff, pend_in;
   logic [MUL_W-1:0] gq_ff, gq_in;
   logic [SB-1:0]    re_res_ff, re_res_in;
   logic [SB-1:0]    im_res_ff, im_res_in;

   logic              mul_en;
   logic [MUL_W-1:0]  mul_a;
   logic [MUL_W-1:0]  mul_b;
   logic [PROD_W-1:0] prod;

   logic signed [CNT_W:0] row_d;
   logic signed [CNT_W:0] col_d;
   logic [MUL_W-1:0]      g_cur;
   logic [PROD_W-1:0]     e_sum;
   logic [FRAC_IDX_W-1:0] lead_pos;
   logic [FRAC_IDX_W-1:0] tab_idx;

   // Magnitude of (+/-p) - offset, saturated at 2^31.
   function automatic logic [MUL_W-1:0] coord_mag(input logic neg,
                                                  input logic [PW-1:0] p,
                                                  input logic [CFG_W-1:0] off);
      logic signed [XW-1:0] ps;
      logic signed [XW-1:0] xs;
      logic [XW-1:0]        xm;
      ps = signed'(XW'(p));
      if (neg) begin
         ps = -ps;
      end
      xs = ps - signed'({{(XW - CFG_W){off[CFG_W-1]}}, off});
      xm = xs[XW-1] ? unsigned'(-xs) : unsigned'(xs);
      return (xm > COORD_SAT) ? MUL_W'(COORD_SAT) : xm[MUL_W-1:0];
   endfunction

   // Drop the Q16 fraction of |sample| * gain, restore the sign, saturate.
   function automatic logic [SB-1:0] saturate(input logic [PROD_W-1:0] p,
                                              input logic neg);
      logic [Q_W-1:0] q;
      q = p[PROD_W-1:16];
      if (neg) begin
         if (q > SAT_NEG) begin
            q = SAT_NEG;
         end
         return -q[SB-1:0];
      end
      if (q > SAT_POS) begin
         q = SAT_POS;
      end
      return q[SB-1:0];
   endfunction

   gafm_mult u_mult (
      .clock   (clock),
      .mul_en  (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      row_neg_in   = row_neg_ff;
      row_mag_in   = row_mag_ff;
      col_neg_in   = col_neg_ff;
      col_mag_in   = col_mag_ff;
      re_neg_in    = re_neg_ff;
      re_mag_in    = re_mag_ff;
      im_neg_in    = im_neg_ff;
      im_mag_in    = im_mag_ff;
      frame_in     = frame_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      s_in         = s_ff;
      acc_in       = acc_ff;
      e_in         = e_ff;
      frac_in      = frac_ff;
      tint_in      = tint_ff;
      g_in         = g_ff;
      pend_in      = pend_ff;
      gq_in        = gq_ff;
      re_res_in    = re_res_ff;
      im_res_in    = im_res_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      row_d = signed'({1'b0, row_index}) - signed'({1'b0, grid_half});
      col_d = signed'({1'b0, column_index}) - signed'({1'b0, grid_half});
      g_cur = pend_ff ? prod[62:31] : g_ff;
      e_sum = prod + PROD_W'(acc_ff);

      // Highest remaining fraction bit is the smallest table index.
      lead_pos = '0;
      for (int i = 0; i < FRAC_BITS; i++) begin
         if (frac_ff[i]) begin
            lead_pos = FRAC_IDX_W'(i);
         end
      end
      tab_idx = FRAC_IDX_W'(FRAC_BITS) - lead_pos;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               row_neg_in = row_d[CNT_W];
               row_mag_in = row_d[CNT_W] ? CNT_W'(-row_d) : row_d[CNT_W-1:0];
               col_neg_in = col_d[CNT_W];
               col_mag_in = col_d[CNT_W] ? CNT_W'(-col_d) : col_d[CNT_W-1:0];
               re_neg_in  = req_data.sample_re[SB-1];
               re_mag_in  = req_data.sample_re[SB-1] ? unsigned'(-req_data.sample_re)
                                                     : unsigned'(req_data.sample_re);
               im_neg_in  = req_data.sample_im[SB-1];
               im_mag_in  = req_data.sample_im[SB-1] ? unsigned'(-req_data.sample_im)
                                                     : unsigned'(req_data.sample_im);
               frame_in   = frame_last;
               state_in   = ST_CROW;
            end
         end
         ST_CROW: begin
            mul_en   = 1'b1;
            mul_a    = MUL_W'(row_mag_ff);
            mul_b    = cfg.pixel_pitch;
            state_in = ST_CCOL;
         end
         ST_CCOL: begin
            ax_in    = coord_mag(row_neg_ff, prod[PW-1:0], cfg.x_offset);
            mul_en   = 1'b1;
            mul_a    = MUL_W'(col_mag_ff);
            mul_b    = cfg.pixel_pitch;
            state_in = ST_SQX;
         end
         ST_SQX: begin
            ay_in    = coord_mag(col_neg_ff, prod[PW-1:0], cfg.y_offset);
            mul_en   = 1'b1;
            mul_a    = ax_ff;
            mul_b    = ax_ff;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            s_in     = prod;
            mul_en   = 1'b1;
            mul_a    = ay_ff;
            mul_b    = ay_ff;
            state_in = ST_SUMS;
         end
         ST_SUMS: begin
            s_in     = s_ff + prod;
            state_in = ST_ELO;
         end
         ST_ELO: begin
            mul_en   = 1'b1;
            mul_a    = s_ff[MUL_W-1:0];
            mul_b    = cfg.inv_two_radius_sq;
            state_in = ST_EHI;
         end
         ST_EHI: begin
            acc_in   = prod[PROD_W-1:MUL_W];
            mul_en   = 1'b1;
            mul_a    = s_ff[PROD_W-1:MUL_W];
            mul_b    = cfg.inv_two_radius_sq;
            state_in = ST_ESUM;
         end
         ST_ESUM: begin
            if (e_sum > CUTOFF_Q24) begin
               // Gain is zero, so both results are zero.
               re_res_in = '0;
               im_res_in = '0;
               state_in  = ST_DONE;
            end else begin
               e_in     = e_sum[MUL_W-1:0];
               state_in = ST_TMUL;
            end
         end
         ST_TMUL: begin
            mul_en   = 1'b1;
            mul_a    = e_ff;
            mul_b    = LOG2E_Q30;
            state_in = ST_TGET;
         end
         ST_TGET: begin
            frac_in  = prod[53:30];
            tint_in  = prod[59:54];
            g_in     = G_ONE;
            pend_in  = 1'b0;
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            if (frac_ff == '0) begin
               g_in     = g_cur >> tint_ff;
               pend_in  = 1'b0;
               state_in = ST_GAIN;
            end else begin
               mul_en            = 1'b1;
               mul_a             = g_cur;
               mul_b             = FRAC_TAB[tab_idx];
               frac_in[lead_pos] = 1'b0;
               pend_in           = 1'b1;
            end
         end
         ST_GAIN: begin
            mul_en   = 1'b1;
            mul_a    = cfg.amplitude_root;
            mul_b    = g_ff;
            state_in = ST_MRE;
         end
         ST_MRE: begin
            gq_in    = prod[62:31];
            mul_en   = 1'b1;
            mul_a    = MUL_W'(re_mag_ff);
            mul_b    = prod[62:31];
            state_in = ST_MIM;
         end
         ST_MIM: begin
            re_res_in = saturate(prod, re_neg_ff);
            mul_en    = 1'b1;
            mul_a     = MUL_W'(im_mag_ff);
            mul_b     = gq_ff;
            state_in  = ST_SIM;
         end
         ST_SIM: begin
            im_res_in = saturate(prod, im_neg_ff);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.masked_re = re_res_ff;
               rsp_data_in.masked_im = im_res_ff;
               rsp_data_in.frame_end = frame_ff;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      row_neg_ff <= row_neg_in;
      row_mag_ff <= row_mag_in;
      col_neg_ff <= col_neg_in;
      col_mag_ff <= col_mag_in;
      re_neg_ff  <= re_neg_in;
      re_mag_ff  <= re_mag_in;
      im_neg_ff  <= im_neg_in;
      im_mag_ff  <= im_mag_in;
      frame_ff   <= frame_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      s_ff       <= s_in;
      acc_ff     <= acc_in;
      e_ff       <= e_in;
      frac_ff    <= frac_in;
      tint_ff    <= tint_in;
      g_ff       <= g_in;
      pend_ff    <= pend_in;
      gq_ff      <= gq_in;
      re_res_ff  <= re_res_in;
      im_res_ff  <= im_res_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/gaussian_aperture_field_mask.sv
// ----------------------------------------------------------------------------
// Gaussian aperture field mask: top level
// Applies a Gaussian aperture gain to each complex sample of an N by N field.
// ----------------------------------------------------------------------------
// Usage: samples enter row-major on the req_ channel as a transaction with
// req_valid high and req_stall low; the block tracks row and column itself.
// Each transaction returns one rsp_ transaction holding both parts scaled by
// amplitude_root * exp(-(x^2 + y^2) * inv_two_radius_sq), saturated, and
// frame_end on the last sample of the grid. Registers are to be written over
// the csr_ channel, which is always ready, only while no sample is in flight;
// the user must see to this, as the block itself does not enforce it.
// All arithmetic runs on one shared 32 by 32 multiplier. The exponent step
// makes one table product for each set fraction bit (0 to 24 of them) of the
// base-2 exponent; a sample beyond the exponent cutoff skips straight to a
// zero result. A new sample is taken only once the sequencer is back in idle
// after loading the result. The result sits in an output register, so the next
// sample is accepted while an earlier result is still stalled; the sequencer
// only waits at its last step if that register is still full.
// Reset (synchronous, active high) clears the counters, empties the output
// register and restores every register to its default.
// ----------------------------------------------------------------------------
`include "gaussian_aperture_field_mask_defines.svh"

module gaussian_aperture_field_mask #(
   parameter int MAX_GRID = gafm_pkg::DEFAULT_MAX_GRID
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gafm_pkg::req_payload_type         req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gafm_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gafm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gafm_pkg::CFG_W-1:0]        csr_data
);
   import gafm_pkg::*;

   localparam int CNT_W = $clog2(MAX_GRID);

   cfg_type          cfg_ff, cfg_in;
   logic             req_accept;
   logic             core_busy;
   logic [CNT_W-1:0] row_index;
   logic [CNT_W-1:0] column_index;
   logic [CNT_W-1:0] grid_half;
   logic             frame_last;

   // Configuration writes are registered directly, so the port never holds off.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_GRID_POINTS:       cfg_in.grid_points       = csr_data[GRID_W-1:0];
            REG_PIXEL_PITCH:       cfg_in.pixel_pitch       = csr_data;
            REG_X_OFFSET:          cfg_in.x_offset          = signed'(csr_data);
            REG_Y_OFFSET:          cfg_in.y_offset          = signed'(csr_data);
            REG_INV_TWO_RADIUS_SQ: cfg_in.inv_two_radius_sq = csr_data;
            REG_AMPLITUDE_ROOT:    cfg_in.amplitude_root    = csr_data;
            default: begin
               // Unmapped indexes are ignored.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_points       <= RST_GRID_POINTS;
         cfg_ff.pixel_pitch       <= RST_PIXEL_PITCH;
         cfg_ff.x_offset          <= signed'(RST_X_OFFSET);
         cfg_ff.y_offset          <= signed'(RST_Y_OFFSET);
         cfg_ff.inv_two_radius_sq <= RST_INV_TWO_R2;
         cfg_ff.amplitude_root    <= RST_AMP_ROOT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The sequencer works on one sample at a time; it is free only in idle.
   assign req_stall  = core_busy;
   assign req_accept = req_valid && !req_stall;

   // The counters advance as a sample is taken; the core latches the
   // position it had before the step.
   gafm_grid_counter #(
      .MAX_GRID (MAX_GRID)
   ) u_grid_counter (
      .clock        (clock),
      .reset        (reset),
      .advance      (req_accept),
      .grid_points  (cfg_ff.grid_points),
      .row_index    (row_index),
      .column_index (column_index),
      .grid_half    (grid_half),
      .frame_last   (frame_last)
   );

   gafm_core #(
      .MAX_GRID (MAX_GRID)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .start        (req_accept),
      .req_data     (req_data),
      .row_index    (row_index),
      .column_index (column_index),
      .grid_half    (grid_half),
      .frame_last   (frame_last),
      .busy         (core_busy),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   // A taken sample must occupy the sequencer in the following cycle.
   `GAFM_ASSERT_NEXT(a_busy_after_accept, req_accept, req_stall, "sequencer idle after accept")

   // A result only appears out of a busy sequencer.
   `GAFM_ASSERT_SAME(a_result_from_busy, $rose(rsp_valid), $past(req_stall), "result without work")

   // The last sample of a frame returns both counters to the origin.
   `GAFM_ASSERT_NEXT(a_frame_wrap, req_accept && frame_last, row_index == '0 && column_index == '0, "grid counters did not wrap")

endmodule
